FILE: rtl/rbsd_pkg.sv
// ---------------------------------------------------------------------------
// rbsd_pkg
// shared types and constants of the raw10 bayer superpixel demosaic
// ---------------------------------------------------------------------------
`default_nettype none

package rbsd_pkg;

  localparam int unsigned MaxGroupsDefault = 1024;
  localparam int unsigned QueueDepth       = 4;
  localparam int unsigned QueueCntW        = $clog2(QueueDepth + 1);
  localparam int unsigned LimitW           = 13;
  localparam int unsigned LineGroupsW      = 11;
  localparam int unsigned ColumnW          = 10;
  localparam int unsigned CfgIndexW        = 2;
  localparam int unsigned CfgDataW         = 11;
  localparam logic [LineGroupsW-1:0] LineGroupsReset = 11'd640;

  typedef enum logic [CfgIndexW-1:0] {
    CfgBayerOrder = 2'd0,
    CfgLineGroups = 2'd1
  } cfg_index_e;

  typedef enum logic [1:0] {
    BayerRggb = 2'd0,
    BayerBggr = 2'd1,
    BayerGrbg = 2'd2,
    BayerGbrg = 2'd3
  } bayer_e;

  // one line pair group on its way to the color stage
  typedef struct packed {
    logic [31:0]        upper_word;
    logic [31:0]        lower_word;
    logic [ColumnW-1:0] column;
    logic               last;
  } pair_t;

  typedef struct packed {
    logic                 not_empty;
    logic [QueueCntW-1:0] count;
  } queue_stat_t;

  function automatic logic [7:0] mean_floor(input logic [7:0] x, input logic [7:0] y);
    logic [8:0] sum;
    sum = {1'b0, x} + {1'b0, y};
    return sum[8:1];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rbsd_ram.sv
// ---------------------------------------------------------------------------
// rbsd_ram
// generic single port ram with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module rbsd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/rbsd_front.sv
// ---------------------------------------------------------------------------
// rbsd_front
// line position tracking, upper line store and lookup of the group above
// ---------------------------------------------------------------------------
`default_nettype none

module rbsd_front import rbsd_pkg::*; #(
  parameter int unsigned MaxGroups = MaxGroupsDefault,
  localparam int unsigned ColW = (MaxGroups > 1) ? $clog2(MaxGroups) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   accept_i,
  input  wire logic [7:0]             pixel_byte_0_i,
  input  wire logic [7:0]             pixel_byte_1_i,
  input  wire logic [7:0]             pixel_byte_2_i,
  input  wire logic [7:0]             pixel_byte_3_i,
  input  wire logic                   start_of_frame_i,
  input  wire logic [LineGroupsW-1:0] line_groups_i,
  input  wire queue_stat_t            q_stat_i,
  output logic                        full_o,
  output logic                        q_push_o,
  output pair_t                       q_data_o
);

  logic [ColW-1:0]   col_q, col_d, col_cur;
  logic              odd_q, odd_d, odd_cur;
  logic [LimitW-1:0] limit;
  logic [LimitW-1:0] col_plus;
  logic              last;
  logic [31:0]       lower_word;
  logic [31:0]       upper_word;
  logic              s1_valid_q;
  logic [31:0]       s1_word_q;
  logic [ColW-1:0]   s1_col_q;
  logic              s1_last_q;
  logic [QueueCntW:0] used;

  assign lower_word = {pixel_byte_3_i, pixel_byte_2_i, pixel_byte_1_i, pixel_byte_0_i};

  always_comb begin
    limit = LimitW'(line_groups_i);
    if (limit == '0) begin
      limit = LimitW'(1);
    end
    if (limit > LimitW'(MaxGroups)) begin
      limit = LimitW'(MaxGroups);
    end
  end

  assign col_cur  = start_of_frame_i ? '0 : col_q;
  assign odd_cur  = start_of_frame_i ? 1'b0 : odd_q;
  assign col_plus = LimitW'(col_cur) + LimitW'(1);
  assign last     = (col_plus >= limit);

  always_comb begin
    col_d = col_q;
    odd_d = odd_q;
    if (accept_i) begin
      if (last) begin
        col_d = '0;
        odd_d = ~odd_cur;
      end else begin
        col_d = col_cur + ColW'(1);
        odd_d = odd_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      odd_q      <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      odd_q      <= odd_d;
      s1_valid_q <= accept_i & odd_cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_word_q <= lower_word;
      s1_col_q  <= col_cur;
      s1_last_q <= last;
    end
  end

  rbsd_ram #(
    .Width (32),
    .Depth (MaxGroups)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (accept_i & ~odd_cur),
    .addr_i  (col_cur),
    .wdata_i (lower_word),
    .rdata_o (upper_word)
  );

  // a slot is held for the group whose store read is in flight
  assign used   = {1'b0, q_stat_i.count} + (QueueCntW + 1)'(s1_valid_q);
  assign full_o = (used >= (QueueCntW + 1)'(QueueDepth));

  assign q_push_o            = s1_valid_q;
  assign q_data_o.upper_word = upper_word;
  assign q_data_o.lower_word = s1_word_q;
  assign q_data_o.column     = ColumnW'(s1_col_q);
  assign q_data_o.last       = s1_last_q;

endmodule

`default_nettype wire

FILE: rtl/rbsd_queue.sv
// ---------------------------------------------------------------------------
// rbsd_queue
// short queue of line pair groups between front and color stage
// ---------------------------------------------------------------------------
`default_nettype none

module rbsd_queue import rbsd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire pair_t data_i,
  input  wire logic  pop_i,
  output pair_t      data_o,
  output queue_stat_t stat_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  pair_t                entry_q [QueueDepth];
  logic [PtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 do_pop;

  assign do_pop = pop_i & (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + QueueCntW'(1);
      end else if (!push_i && do_pop) begin
        count_q <= count_q - QueueCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o           = entry_q[rd_ptr_q];
  assign stat_o.not_empty = (count_q != '0);
  assign stat_o.count     = count_q;

endmodule

`default_nettype wire

FILE: rtl/rbsd_back.sv
// ---------------------------------------------------------------------------
// rbsd_back
// color selection per bayer order, green averaging and result register
// ---------------------------------------------------------------------------
`default_nettype none

module rbsd_back import rbsd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire bayer_e      bayer_order_i,
  input  wire pair_t       q_data_i,
  input  wire queue_stat_t q_stat_i,
  output logic             q_pop_o,
  input  wire logic        pop,
  output logic             empty,
  output logic [7:0]       blue_left_o,
  output logic [7:0]       green_left_o,
  output logic [7:0]       red_left_o,
  output logic [7:0]       blue_right_o,
  output logic [7:0]       green_right_o,
  output logic [7:0]       red_right_o,
  output logic [ColumnW-1:0] group_column_o,
  output logic             end_of_line_o
);

  logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3;
  logic [7:0] bl_d, gl_d, rl_d, br_d, gr_d, rr_d;
  logic       out_valid_q;
  logic       load;

  assign {a3, a2, a1, a0} = q_data_i.upper_word;
  assign {b3, b2, b1, b0} = q_data_i.lower_word;

  always_comb begin
    case (bayer_order_i)
      BayerRggb: begin
        bl_d = b1; gl_d = mean_floor(b0, a1); rl_d = a0;
        br_d = b3; gr_d = mean_floor(b2, a3); rr_d = a2;
      end
      BayerBggr: begin
        bl_d = a0; gl_d = mean_floor(b0, a1); rl_d = b1;
        br_d = a2; gr_d = mean_floor(b2, a3); rr_d = b3;
      end
      BayerGrbg: begin
        bl_d = b0; gl_d = mean_floor(a0, b1); rl_d = a1;
        br_d = b2; gr_d = mean_floor(a2, b3); rr_d = a3;
      end
      default: begin
        bl_d = a1; gl_d = mean_floor(a0, b1); rl_d = b0;
        br_d = a3; gr_d = mean_floor(a2, b3); rr_d = b2;
      end
    endcase
  end

  assign load    = q_stat_i.not_empty & (~out_valid_q | pop);
  assign q_pop_o = load;
  assign empty   = ~out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      blue_left_o    <= bl_d;
      green_left_o   <= gl_d;
      red_left_o     <= rl_d;
      blue_right_o   <= br_d;
      green_right_o  <= gr_d;
      red_right_o    <= rr_d;
      group_column_o <= q_data_i.column;
      end_of_line_o  <= q_data_i.last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/raw10_bayer_superpixel_demosaic.sv
// ---------------------------------------------------------------------------
// raw10_bayer_superpixel_demosaic
// 2x2 superpixel demosaic of packed raw10 bayer groups, high bytes only
// ---------------------------------------------------------------------------
// usage
// - input queue side: push/full, one four-pixel group per item; start_of_frame
//   puts the item at column 0 of an even row
// - even-row items go to the upper line store and give no result; each
//   odd-row item gives one result item with two rgb triples
// - result queue side: empty/pop, the oldest result is on the ports while
//   empty is low
// - one item per cycle sustained while full stays low; a taken item's result
//   passes the store read register, then the queue, then the color register
// - a four-entry queue between the store lookup and the color stage soaks up
//   stalls; full rises when queued and in-flight results fill it, so with pop
//   held low input stops after at most five odd-row items
// - cfg channel: cfg_ready_o is always high, write only while idle;
//   index 0 bayer order, index 1 groups per line, other indexes ignored
// - reset clears position, queue and output state; bayer order goes to rggb
//   and the line to 640 groups; the line store needs no clearing
// ---------------------------------------------------------------------------
`default_nettype none

module raw10_bayer_superpixel_demosaic import rbsd_pkg::*; #(
  parameter int unsigned MaxGroups = MaxGroupsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [7:0]           pixel_byte_0_i,
  input  wire logic [7:0]           pixel_byte_1_i,
  input  wire logic [7:0]           pixel_byte_2_i,
  input  wire logic [7:0]           pixel_byte_3_i,
  input  wire logic                 start_of_frame_i,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [7:0]                blue_left_o,
  output logic [7:0]                green_left_o,
  output logic [7:0]                red_left_o,
  output logic [7:0]                blue_right_o,
  output logic [7:0]                green_right_o,
  output logic [7:0]                red_right_o,
  output logic [ColumnW-1:0]        group_column_o,
  output logic                      end_of_line_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  bayer_e                 bayer_order_q;
  logic [LineGroupsW-1:0] line_groups_q;
  logic                   accept;
  logic                   cfg_we;
  logic                   q_push;
  logic                   q_pop;
  pair_t                  q_wdata;
  pair_t                  q_rdata;
  queue_stat_t            q_stat;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign accept      = push & ~full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bayer_order_q <= BayerRggb;
      line_groups_q <= LineGroupsReset;
    end else if (cfg_we) begin
      case (cfg_index_e'(cfg_index_i))
        CfgBayerOrder: bayer_order_q <= bayer_e'(cfg_data_i[1:0]);
        CfgLineGroups: line_groups_q <= cfg_data_i[LineGroupsW-1:0];
        default: ;
      endcase
    end
  end

  rbsd_front #(
    .MaxGroups (MaxGroups)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .pixel_byte_0_i   (pixel_byte_0_i),
    .pixel_byte_1_i   (pixel_byte_1_i),
    .pixel_byte_2_i   (pixel_byte_2_i),
    .pixel_byte_3_i   (pixel_byte_3_i),
    .start_of_frame_i (start_of_frame_i),
    .line_groups_i    (line_groups_q),
    .q_stat_i         (q_stat),
    .full_o           (full),
    .q_push_o         (q_push),
    .q_data_o         (q_wdata)
  );

  rbsd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .stat_o (q_stat)
  );

  rbsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bayer_order_i  (bayer_order_q),
    .q_data_i       (q_rdata),
    .q_stat_i       (q_stat),
    .q_pop_o        (q_pop),
    .pop            (pop),
    .empty          (empty),
    .blue_left_o    (blue_left_o),
    .green_left_o   (green_left_o),
    .red_left_o     (red_left_o),
    .blue_right_o   (blue_right_o),
    .green_right_o  (green_right_o),
    .red_right_o    (red_right_o),
    .group_column_o (group_column_o),
    .end_of_line_o  (end_of_line_o)
  );

endmodule

`default_nettype wire
